// ===== sv/rpd_pkg.sv =====
// rpd_pkg: shared constants, types and the Lehmer step for the random pixel dissolve.
// No dependencies; imported by random_pixel_dissolve_unit, rpd_checker and the testbench.
`default_nettype none
package rpd_pkg;

   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned RAND_W      = 31;
   localparam int unsigned THRESH_W    = 25;
   localparam int unsigned MULT_W      = 16;
   localparam int unsigned PROD_W      = RAND_W + MULT_W;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [RAND_W-1:0]   LEHMER_MODULUS = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0]   LEHMER_MULT    = 16'd48271;
   localparam logic [RAND_W-1:0]   SEED_DEFAULT   = 31'd123456789;
   localparam logic [THRESH_W-1:0] THRESH_DEFAULT = 25'd3355443;

   // register index (word address)
   localparam logic CSR_IDX_THRESHOLD = 1'b0;
   localparam logic CSR_IDX_SEED      = 1'b1;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               cleared;
   } result_type;

   // x * 48271 mod (2^31 - 1), by folding the high bits back onto the low ones
   function automatic logic [RAND_W-1:0] lehmer_next(input logic [RAND_W-1:0] x);
      logic [PROD_W-1:0] prod;
      logic [RAND_W:0]   sum;
      logic [RAND_W-1:0] fold;
      prod = PROD_W'(x) * PROD_W'(LEHMER_MULT);
      sum  = {1'b0, prod[RAND_W-1:0]} + (RAND_W+1)'(prod[PROD_W-1:RAND_W]);
      fold = sum[RAND_W-1:0] + RAND_W'(sum[RAND_W]);
      return (fold == LEHMER_MODULUS) ? '0 : fold;
   endfunction

endpackage
`default_nettype wire

// ===== sv/random_pixel_dissolve_unit.sv =====
// random_pixel_dissolve_unit: top level of the random pixel dissolve.
// Depends on rpd_pkg.
`default_nettype none
// Random pixel dissolve. RGBA pixels enter in raster order, one item per
// clock while req_stall is low, and leave through a result register.
// For every accepted item the Park-Miller generator (x * 48271 mod 2^31-1)
// advances once; if the low 24 bits of the new value are below
// clear_threshold the pixel leaves as zero with was_cleared set, otherwise it
// passes unchanged. An item with first_of_image set reloads the generator
// from start_seed before the advance, so each image dissolves the same way.
// Sustained rate is one item per cycle while unstalled; the figure is set
// by the generator update (one 31x16 multiply, fold and compare) that closes
// on its own register every cycle. A two-entry output (result register plus
// skid) keeps req_stall registered: it rises only when both entries hold items.
// Registers: 0x0 clear_threshold (25 bits, 2^24 or above clears all),
// 0x4 start_seed (31 bits). Write them only while no item is in flight.
// After reset the generator starts from 123456789 until first_of_image.
module random_pixel_dissolve_unit
   import rpd_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   // input items
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [PIXEL_W-1:0]     req_pixel_in,
   input  wire                    req_first_of_image,
   // result items
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   output logic                   rsp_was_cleared,
   // configuration
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   // configuration registers
   logic [THRESH_W-1:0] threshold_ff;
   logic [RAND_W-1:0]   seed_ff;
   logic                csr_idx;
   logic                csr_wr;

   // generator state
   logic [RAND_W-1:0]   rand_ff, rand_in;
   logic [RAND_W-1:0]   rand_base;

   // output register and skid entry
   result_type          out_ff, out_in;
   result_type          skid_ff, skid_in;
   result_type          new_res;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;

   logic                accept;
   logic                out_free;

   // --- configuration port ---
   // word index from the byte address; sub-word address bits are ignored
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_DEFAULT;
         seed_ff      <= SEED_DEFAULT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_IDX_THRESHOLD: threshold_ff <= csr_pwdata[THRESH_W-1:0];
            CSR_IDX_SEED:      seed_ff      <= csr_pwdata[RAND_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_IDX_THRESHOLD: csr_prdata = CSR_DATA_W'(threshold_ff);
         CSR_IDX_SEED:      csr_prdata = CSR_DATA_W'(seed_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // --- item path ---
   // stall only when the skid holds an item, so req_stall comes from a flop
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   // the result register can take a new entry this cycle
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   // seed reload happens before the advance
   assign rand_base = req_first_of_image ? seed_ff : rand_ff;

   always_comb begin
      rand_in         = accept ? lehmer_next(rand_base) : rand_ff;
      // low 24 random bits against the 25-bit threshold
      new_res.cleared = ({1'b0, rand_in[THRESH_W-2:0]} < threshold_ff);
      new_res.pixel   = new_res.cleared ? '0 : req_pixel_in;
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid first; no item is accepted this cycle
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_res;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = new_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rand_ff       <= SEED_DEFAULT;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rand_ff       <= rand_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_out   = out_ff.pixel;
   assign rsp_was_cleared = out_ff.cleared;

endmodule
`default_nettype wire

// ===== sv/rpd_checker.sv =====
// rpd_checker: port-level assertions for random_pixel_dissolve_unit, plus its bind.
// Depends on rpd_pkg.
`default_nettype none
module rpd_checker
   import rpd_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_stall,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input wire [PIXEL_W-1:0]   rsp_pixel_out,
   input wire                 rsp_was_cleared
);

   // a stalled result item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_was_cleared))
      else $error("stalled result item changed");

   // a cleared item carries a zero pixel
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_cleared |-> rsp_pixel_out == '0)
      else $error("cleared item with nonzero pixel");

   // input stalls only when the output side already holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

   // after an accepted item, rsp_valid is always high in the next cycle
   a_accept_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item produced no result");

   // nothing pending out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("items pending after reset");

endmodule

bind random_pixel_dissolve_unit rpd_checker u_rpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pixel_out   (rsp_pixel_out),
   .rsp_was_cleared (rsp_was_cleared)
);
`default_nettype wire

// ===== test/tb_random_pixel_dissolve_unit.sv =====
// Self-checking testbench for random_pixel_dissolve_unit: pixel stream in, dissolved stream out.
// Predicts each result with its own Lehmer generator and compares in order; needs rpd_pkg.
`timescale 1ns / 100ps
module tb_random_pixel_dissolve_unit;
   import rpd_pkg::*;

   // one input item as queued for the driver
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               first;
   } pixel_item;

   localparam logic [CSR_ADDR_W-1:0] THRESHOLD_ADDR = {CSR_IDX_THRESHOLD, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR      = {CSR_IDX_SEED, 2'b00};
   localparam int LOW_BITS        = 24;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 255;
   localparam int SETTLE_CYCLES   = 4;     // result register plus skid, with margin
   localparam int STUCK_LIMIT     = 2000;  // well above the longest gap or stall that pick_gap draws
   localparam int REPORT_LIMIT    = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel_in = '0;
   logic                  req_first_of_image = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIXEL_W-1:0]    rsp_pixel_out;
   logic                  rsp_was_cleared;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   random_pixel_dissolve_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_in       (req_pixel_in),
      .req_first_of_image (req_first_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_out      (rsp_pixel_out),
      .rsp_was_cleared    (rsp_was_cleared),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the block: generator value and both registers, all at reset values.
   logic [RAND_W-1:0]   gen_value       = SEED_DEFAULT;
   logic [THRESH_W-1:0] model_threshold = THRESH_DEFAULT;
   logic [RAND_W-1:0]   model_seed      = SEED_DEFAULT;

   pixel_item  pixel_feed[$];       // items waiting for the driver
   result_type pending_results[$];  // predicted results, oldest first

   int   items_queued   = 0;
   int   items_accepted = 0;
   int   mismatches     = 0;
   int   stuck_cycles   = 0;
   logic req_taken      = 1'b0;     // input item went in at the last rising edge
   int   send_wait      = 0;
   int   send_calm      = 0;
   int   recv_hold      = 0;
   int   recv_calm      = 0;

   // x * 48271 mod (2^31 - 1), straight 64-bit arithmetic
   function automatic logic [RAND_W-1:0] lehmer_advance(logic [RAND_W-1:0] x);
      longint unsigned prod;
      prod = 64'(x) * 64'(LEHMER_MULT);
      return RAND_W'(prod % 64'(LEHMER_MODULUS));
   endfunction

   // Advance the shadow generator for one pixel and form its result.
   function automatic result_type dissolve_predict(logic [PIXEL_W-1:0] pixel, logic first);
      result_type r;
      if (first) gen_value = model_seed;
      gen_value = lehmer_advance(gen_value);
      // threshold is 25 bits wide, so 2^24 and up clears every pixel
      r.cleared = ({1'b0, gen_value[LOW_BITS-1:0]} < model_threshold);
      r.pixel   = r.cleared ? '0 : pixel;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one; none during a calm stretch.
   function automatic int pick_gap(logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch in %s: expected %h, got %h", what, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents queued items at the falling edge. An item stays put
   // until taken; the gap drawn for it runs only after it has gone in.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pixel_item next_item;
      if (send_calm > 0) begin
         send_calm <= send_calm - 1;
      end else if ($urandom_range(0, 199) == 0) begin
         send_calm <= $urandom_range(20, 100);
      end
      if (!reset && (!req_valid || req_taken)) begin
         if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pixel_feed.size() != 0) begin
            next_item = pixel_feed.pop_front();
            req_valid          <= 1'b1;
            req_pixel_in       <= next_item.pixel;
            req_first_of_image <= next_item.first;
            send_wait          <= pick_gap(send_calm != 0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: random stall bursts, with calm stretches too.
   always @(negedge clock) begin
      if (recv_calm > 0) begin
         recv_calm <= recv_calm - 1;
      end else if ($urandom_range(0, 199) == 0) begin
         recv_calm <= $urandom_range(20, 100);
      end
      if (recv_hold > 0) begin
         rsp_stall <= 1'b1;
         recv_hold <= recv_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) recv_hold <= pick_gap(recv_calm != 0);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: at the rising edge, predict for each item taken in and check
   // each result item taken out against the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            pending_results.push_back(dissolve_predict(req_pixel_in, req_first_of_image));
            items_accepted <= items_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 64'd0,
                               64'({rsp_was_cleared, rsp_pixel_out}));
            end else begin
               want = pending_results.pop_front();
               if (rsp_pixel_out !== want.pixel)
                  report_mismatch("pixel_out", 64'(want.pixel), 64'(rsp_pixel_out));
               if (rsp_was_cleared !== want.cleared)
                  report_mismatch("was_cleared", 64'(want.cleared), 64'(rsp_was_cleared));
            end
         end
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // One register access: setup cycle, then access until pready.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read both registers back and compare with the shadow copies.
   task automatic check_registers();
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, THRESHOLD_ADDR, '0, got);
      if (got !== CSR_DATA_W'(model_threshold))
         report_mismatch("clear_threshold readback", 64'(model_threshold), 64'(got));
      csr_access(1'b0, SEED_ADDR, '0, got);
      if (got !== CSR_DATA_W'(model_seed))
         report_mismatch("start_seed readback", 64'(model_seed), 64'(got));
   endtask

   // Only called with nothing in flight.
   task automatic write_registers(logic [THRESH_W-1:0] thresh, logic [RAND_W-1:0] seed);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, THRESHOLD_ADDR, CSR_DATA_W'(thresh), unused);
      csr_access(1'b1, SEED_ADDR, CSR_DATA_W'(seed), unused);
      model_threshold = thresh;
      model_seed      = seed;
      check_registers();
   endtask

   task automatic queue_item(logic [PIXEL_W-1:0] pixel, logic first);
      pixel_feed.push_back('{pixel: pixel, first: first});
      items_queued++;
   endtask

   // Sender holds off until every item is in and every result is out.
   task automatic wait_until_drained();
      while (items_accepted != items_queued || pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Corner settings: a short image of three pixels under each.
   task automatic corner_phase(logic [THRESH_W-1:0] thresh, logic [RAND_W-1:0] seed);
      write_registers(thresh, seed);
      queue_item($urandom, 1'b1);
      queue_item($urandom, 1'b0);
      queue_item($urandom, 1'b0);
      wait_until_drained();
   endtask

   initial begin
      logic [THRESH_W-1:0] thresh;
      logic [RAND_W-1:0]   seed;
      int                  run;
      int                  queued_in_phase;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values, then a new seed that must not matter until an image starts:
      // the generator keeps running from its reset value.
      check_registers();
      write_registers(THRESH_DEFAULT, 31'd42);
      queue_item(32'h0000_0000, 1'b0);
      queue_item(32'hFFFF_FFFF, 1'b0);
      queue_item(32'hAAAA_AAAA, 1'b0);
      queue_item(32'h5555_5555, 1'b0);
      queue_item(32'h8000_0001, 1'b0);
      queue_item($urandom, 1'b0);
      queue_item($urandom, 1'b1);  // now the new seed takes effect
      queue_item($urandom, 1'b0);
      wait_until_drained();

      corner_phase(25'd0, 31'd1);                  // nothing cleared, smallest seed
      corner_phase(25'h100_0000, 31'h7FFF_FFFE);   // everything cleared, largest seed
      corner_phase(25'h1FF_FFFF, 31'd0);           // threshold above 2^24; stuck-at-zero seed
      corner_phase(25'd0, 31'd0);                  // zero generator but nothing cleared
      corner_phase(25'd1, 31'h7FFF_FFFF);          // seed equal to the modulus folds to zero
      corner_phase(25'h080_0000, SEED_DEFAULT);

      // Random part: mostly whole images starting with first_of_image,
      // some headless runs that just continue the current sequence.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0:       thresh = '0;
            1:       thresh = 25'h100_0000;
            2:       thresh = THRESH_W'($urandom_range(32'h100_0000, 32'h1FF_FFFF));
            default: thresh = THRESH_W'($urandom_range(0, 32'h100_0000));
         endcase
         case ($urandom_range(0, 19))
            0:       seed = '0;
            1:       seed = 31'h7FFF_FFFF;
            2:       seed = 31'd1;
            3:       seed = 31'h7FFF_FFFE;
            default: seed = RAND_W'($urandom_range(1, 32'h7FFF_FFFE));
         endcase
         write_registers(thresh, seed);
         queued_in_phase = 0;
         while (queued_in_phase < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) != 0) begin
               run = $urandom_range(1, 48);
               for (int k = 0; k < run; k++) queue_item($urandom, k == 0);
            end else begin
               run = $urandom_range(1, 8);
               for (int k = 0; k < run; k++) queue_item($urandom, 1'b0);
            end
            queued_in_phase += run;
         end
         wait_until_drained();
      end

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
